/* rtl/core/rmt_pkg.sv */
// ring management package: types, codes and constants
// no dependencies
package rmt_pkg;

	localparam int unsigned MaxTransitions = 8;
	localparam int unsigned StepW = $clog2(MaxTransitions + 1);

	typedef enum logic [1:0] {
		CMD_EVAL = 2'd0,
		CMD_RESET = 2'd1,
		CMD_DUP = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam logic [2:0] S_ISO = 3'd0;
	localparam logic [2:0] S_NONOP = 3'd1;
	localparam logic [2:0] S_RINGOP = 3'd2;
	localparam logic [2:0] S_DETECT = 3'd3;
	localparam logic [2:0] S_NONOP_DUP = 3'd4;
	localparam logic [2:0] S_RINGOP_DUP = 3'd5;
	localparam logic [2:0] S_DIRECTED = 3'd6;
	localparam logic [2:0] S_TRACE = 3'd7;

	localparam logic [1:0] ECM_OUT = 2'd0;
	localparam logic [1:0] ECM_IN = 2'd1;
	localparam logic [1:0] ECM_TRACE = 2'd2;

	localparam logic [1:0] TS_NONE = 2'd0;
	localparam logic [1:0] TS_INIT = 2'd1;
	localparam logic [1:0] TS_PROP = 2'd2;
	localparam logic [1:0] TS_TERM = 2'd3;

	localparam logic [1:0] MRR_NONE = 2'd0;
	localparam logic [1:0] MRR_OFF = 2'd1;
	localparam logic [1:0] MRR_ON = 2'd2;

	localparam logic [1:0] DAT_UNKNOWN = 2'd0;
	localparam logic [1:0] DAT_PASS = 2'd1;
	localparam logic [1:0] DAT_FAIL = 2'd2;

	localparam logic [2:0] R_TRACE_EN = 3'd0;
	localparam logic [2:0] R_HOLD = 3'd1;
	localparam logic [2:0] R_NONOP_T = 3'd2;
	localparam logic [2:0] R_STUCK_T = 3'd3;
	localparam logic [2:0] R_ANNOUNCE_T = 3'd4;
	localparam logic [2:0] R_DIRECT_T = 3'd5;
	localparam logic [2:0] R_SULK = 3'd6;
	localparam logic [2:0] R_MAX_FLOPS = 3'd7;

	// internal flag bit positions
	localparam int unsigned F_NO = 0;
	localparam int unsigned F_RE = 1;
	localparam int unsigned F_LAV = 2;
	localparam int unsigned F_MAV = 3;
	localparam int unsigned F_BN = 4;
	localparam int unsigned F_JM = 5;
	localparam int unsigned F_DUP = 6;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] now_sec;
		logic join_req;
		logic loop;
		logic own_beacon;
		logic other_beacon;
		logic trt_expired;
		logic t4_or_t5;
		logic dup_detected;
		logic ring_operational;
		logic [1:0] dupa_result;
		logic port_in_trace;
	} rmt_in_t;

	typedef struct packed {
		logic [2:0] rm_state;
		logic [1:0] ecm_code;
		logic [1:0] trace_status;
		logic loop_avail;
		logic mac_avail;
		logic dup_addr_flag;
		logic start_directed_beacon;
		logic stop_directed_beacon;
		logic start_trace;
		logic [1:0] mac_reset_request;
		logic dup_alarm;
		logic timer_running;
	} rmt_out_t;

	typedef struct packed {
		logic trace_enable;
		logic hold_available;
		logic [7:0] non_op_time;
		logic [7:0] stuck_time;
		logic [7:0] announce_time;
		logic [7:0] direct_time;
		logic [9:0] sulk_unit;
		logic [3:0] max_flops;
	} rmt_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture a new request and run its prologue
		logic step;   // run one state body pass
		logic mul;    // compute backoff product
	} rmt_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic run;    // prologue asks for evaluation
		logic chain;  // current pass chains on
	} rmt_sts_t;

endpackage

/* rtl/core/rmt_if.sv */
// valid/ready channel interfaces for ring management
// depends on rmt_pkg
interface rmt_in_if;
	logic valid;
	logic ready;
	rmt_pkg::rmt_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rmt_out_if;
	logic valid;
	logic ready;
	rmt_pkg::rmt_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rmt_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [9:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/core/rmt_ctrl.sv */
// ring management controller: sequences load, backoff multiply and passes
// depends on rmt_pkg
module rmt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output rmt_pkg::rmt_ctl_t ctl,
	input rmt_pkg::rmt_sts_t sts
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL = 4'b0010,
		ST_PASS = 4'b0100,
		ST_DONE = 4'b1000
	} st_t;

	st_t state_q;
	logic [rmt_pkg::StepW-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign ctl.load = in_valid && in_ready;
	assign ctl.mul = (state_q == ST_MUL);
	assign ctl.step = (state_q == ST_PASS);

	// state register and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL;
					cnt_q <= '0;
				end
				ST_MUL: begin
					if (sts.run) state_q <= ST_PASS;
					else state_q <= ST_DONE;
				end
				ST_PASS: begin
					cnt_q <= cnt_q + 1'b1;
					if (!sts.chain ||
						cnt_q == rmt_pkg::StepW'(rmt_pkg::MaxTransitions - 1))
						state_q <= ST_DONE;
					else
						state_q <= ST_MUL;
				end
				ST_DONE: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* rtl/core/rmt_dp.sv */
// ring management datapath: state, flags, timer, backoff and pulses
// depends on rmt_pkg
module rmt_dp (
	input logic clk,
	input logic arst_n,
	input rmt_pkg::rmt_cfg_t cfg,
	input rmt_pkg::rmt_in_t in_data,
	input rmt_pkg::rmt_ctl_t ctl,
	output rmt_pkg::rmt_sts_t sts,
	output rmt_pkg::rmt_out_t out_data
);
	logic [2:0] st_q;
	logic [6:0] fl_q;
	logic [31:0] base_q;
	logic tact_q;
	logic [3:0] flop_q;
	logic dupf_q, marked_q;
	logic [1:0] dupa_q, ecm_q, ts_q;
	logic sdb_q, stdb_q, str_q, alarm_q;
	logic [1:0] mrr_q;
	logic run_q;
	rmt_pkg::rmt_in_t c_q;
	logic [13:0] prod_q;

	// limit checks against the captured second, no wrap
	function automatic logic passed(input logic [31:0] base, input logic [31:0] now,
		input logic [13:0] v);
		logic [32:0] s;
		s = {1'b0, base} + {19'd0, v};
		return s <= {1'b0, now};
	endfunction

	logic bcn;
	assign bcn = c_q.own_beacon | c_q.other_beacon;

	// next-value logic for one pass or prologue
	logic [2:0] n_st;
	logic [6:0] n_fl;
	logic [31:0] n_base;
	logic n_tact, n_dupf, n_chain, n_run, n_marked;
	logic [3:0] n_flop;
	logic [1:0] n_ecm, n_ts, n_mrr, n_dupa;
	logic n_sdb, n_stdb, n_str, n_alarm;

	assign sts.run = run_q;
	assign sts.chain = n_chain;

	always_comb begin
		logic [6:0] f;
		logic [1:0] dr;
		logic iso, nonop, ringop, detect, nondup, rdup, directed, trace_e, dact;
		n_st = st_q; n_fl = fl_q; n_base = base_q; n_tact = tact_q;
		n_dupf = dupf_q; n_flop = flop_q; n_ecm = ecm_q; n_ts = ts_q;
		n_mrr = mrr_q; n_dupa = dupa_q; n_sdb = sdb_q; n_stdb = stdb_q;
		n_str = str_q; n_alarm = alarm_q; n_chain = 1'b0; n_run = 1'b0;
		n_marked = marked_q;
		f = fl_q;
		dr = in_data.dupa_result;
		iso = 1'b0; nonop = 1'b0; ringop = 1'b0; detect = 1'b0; nondup = 1'b0;
		rdup = 1'b0; directed = 1'b0; trace_e = 1'b0; dact = 1'b0;
		if (ctl.load) begin
			n_sdb = 1'b0; n_stdb = 1'b0; n_str = 1'b0; n_mrr = rmt_pkg::MRR_NONE;
			n_alarm = 1'b0;
			if (in_data.cmd != rmt_pkg::CMD_NONE &&
				(dr == rmt_pkg::DAT_PASS || dr == rmt_pkg::DAT_FAIL))
				n_dupa = dr;
			unique case (rmt_pkg::cmd_t'(in_data.cmd))
				rmt_pkg::CMD_EVAL: n_run = 1'b1;
				rmt_pkg::CMD_RESET: iso = 1'b1;
				rmt_pkg::CMD_DUP: begin
					n_dupa = rmt_pkg::DAT_FAIL;
					if (!marked_q) begin
						n_marked = 1'b1;
						n_alarm = 1'b1;
						n_run = 1'b1;
					end
				end
				default: ;
			endcase
			// evaluation prologue
			if (n_run) begin
				if (!cfg.trace_enable) begin
					n_tact = 1'b0;
					n_run = 1'b0;
				end else begin
					if (in_data.port_in_trace && st_q != rmt_pkg::S_TRACE) begin
						n_st = rmt_pkg::S_TRACE;
						n_ecm = rmt_pkg::ECM_TRACE;
						n_ts = rmt_pkg::TS_PROP;
					end
					if (!in_data.join_req && !in_data.loop && !f[rmt_pkg::F_DUP] &&
						n_st != rmt_pkg::S_ISO)
						iso = 1'b1;
				end
			end
			if (iso) begin
				n_st = rmt_pkg::S_ISO;
				n_fl = 7'd0;
				n_fl[rmt_pkg::F_NO] = 1'b1;
				n_fl[rmt_pkg::F_RE] = !cfg.hold_available;
				if (n_ts == rmt_pkg::TS_INIT || n_ts == rmt_pkg::TS_PROP)
					n_ts = rmt_pkg::TS_TERM;
				n_ecm = rmt_pkg::ECM_OUT;
				n_tact = 1'b0;
			end
		end else if (ctl.step) begin
			unique case (st_q)
				rmt_pkg::S_ISO: begin
					if (c_q.join_req || c_q.loop) begin nonop = 1'b1; n_chain = 1'b1; end
				end
				rmt_pkg::S_NONOP: begin
					if (cfg.hold_available && !f[rmt_pkg::F_NO] &&
						(bcn || (c_q.trt_expired && c_q.t4_or_t5))) begin
						n_fl[rmt_pkg::F_NO] = 1'b1; nonop = 1'b1; n_chain = 1'b1;
					end else if (c_q.ring_operational) begin
						ringop = 1'b1; n_chain = 1'b1;
					end else if (passed(base_q, c_q.now_sec, {6'd0, cfg.non_op_time})) begin
						n_fl[rmt_pkg::F_BN] = 1'b0; n_fl[rmt_pkg::F_NO] = 1'b1;
						detect = 1'b1; n_chain = 1'b1;
					end
				end
				rmt_pkg::S_RINGOP: begin
					if (!c_q.ring_operational) begin
						nonop = 1'b1; n_chain = 1'b1;
					end else if (dupa_q == rmt_pkg::DAT_FAIL) begin
						n_fl[rmt_pkg::F_LAV] = 1'b0; n_fl[rmt_pkg::F_MAV] = 1'b0;
						n_dupf = 1'b1; rdup = 1'b1;
					end
				end
				rmt_pkg::S_DETECT: begin
					if (c_q.ring_operational) begin
						ringop = 1'b1; n_chain = 1'b1;
					end else if (f[rmt_pkg::F_BN] && bcn) begin
						n_fl[rmt_pkg::F_BN] = 1'b0; detect = 1'b1; n_chain = 1'b1;
					end else if (!f[rmt_pkg::F_BN] && c_q.trt_expired && c_q.t4_or_t5 &&
						!bcn) begin
						n_fl[rmt_pkg::F_BN] = 1'b1; detect = 1'b1; n_chain = 1'b1;
					end else if (c_q.dup_detected) begin
						n_dupf = 1'b1; n_fl[rmt_pkg::F_BN] = 1'b0; n_fl[rmt_pkg::F_JM] = 1'b0;
						dact = 1'b1; n_chain = 1'b1;
					end else if (passed(base_q, c_q.now_sec, {6'd0, cfg.stuck_time}) &&
						c_q.join_req && f[rmt_pkg::F_BN]) begin
						directed = 1'b1; n_chain = 1'b1;
					end
				end
				rmt_pkg::S_NONOP_DUP: begin
					if (c_q.ring_operational) begin
						rdup = 1'b1; n_chain = 1'b1;
					end else if (f[rmt_pkg::F_BN] && bcn) begin
						n_fl[rmt_pkg::F_BN] = 1'b0; nondup = 1'b1; n_chain = 1'b1;
					end else if (!f[rmt_pkg::F_BN] && c_q.trt_expired && c_q.t4_or_t5) begin
						n_fl[rmt_pkg::F_BN] = 1'b1; nondup = 1'b1; n_chain = 1'b1;
					end else if (!f[rmt_pkg::F_BN] && !f[rmt_pkg::F_DUP] &&
						passed(base_q, c_q.now_sec, {6'd0, cfg.announce_time})) begin
						n_fl[rmt_pkg::F_NO] = 1'b1; dact = 1'b1;
					end else if (c_q.join_req && f[rmt_pkg::F_BN] &&
						passed(base_q, c_q.now_sec, {6'd0, cfg.stuck_time})) begin
						directed = 1'b1; n_chain = 1'b1;
					end else if (f[rmt_pkg::F_DUP] && passed(base_q, c_q.now_sec, prod_q)) begin
						n_dupf = 1'b0; iso = 1'b1; n_mrr = rmt_pkg::MRR_ON; n_chain = 1'b1;
					end
				end
				rmt_pkg::S_RINGOP_DUP: begin
					if (dupa_q == rmt_pkg::DAT_PASS) begin
						n_dupf = 1'b0; ringop = 1'b1; n_chain = 1'b1;
					end else if (!c_q.ring_operational) begin
						n_fl[rmt_pkg::F_JM] = 1'b0; n_fl[rmt_pkg::F_BN] = 1'b0;
						dact = 1'b1; n_chain = 1'b1;
					end
				end
				rmt_pkg::S_DIRECTED: begin
					if (bcn) begin
						n_fl[rmt_pkg::F_BN] = 1'b0; n_stdb = 1'b1; n_chain = 1'b1;
						if (!dupf_q) detect = 1'b1;
						else dact = 1'b1;
					end else if (passed(base_q, c_q.now_sec, {6'd0, cfg.direct_time}) &&
						f[rmt_pkg::F_RE]) begin
						trace_e = 1'b1; n_chain = 1'b1;
					end
				end
				default: ;
			endcase
			// entry actions
			if (dact) begin
				if (flop_q < cfg.max_flops) n_flop = flop_q + 4'd1;
				n_mrr = rmt_pkg::MRR_OFF;
				n_fl[rmt_pkg::F_DUP] = 1'b1;
				nondup = 1'b1;
			end
			if (iso) begin
				n_st = rmt_pkg::S_ISO;
				n_fl = 7'd0;
				n_fl[rmt_pkg::F_NO] = 1'b1;
				n_fl[rmt_pkg::F_RE] = !cfg.hold_available;
				if (ts_q == rmt_pkg::TS_INIT || ts_q == rmt_pkg::TS_PROP)
					n_ts = rmt_pkg::TS_TERM;
				n_ecm = rmt_pkg::ECM_OUT;
				n_tact = 1'b0;
			end
			if (nonop) begin
				n_st = rmt_pkg::S_NONOP;
				n_fl[rmt_pkg::F_LAV] = 1'b0; n_fl[rmt_pkg::F_MAV] = 1'b0;
				n_ts = rmt_pkg::TS_NONE; n_ecm = rmt_pkg::ECM_IN;
				n_base = c_q.now_sec; n_tact = 1'b1;
			end
			if (ringop) begin
				n_st = rmt_pkg::S_RINGOP;
				n_fl[rmt_pkg::F_NO] = 1'b0;
				if (c_q.loop) n_fl[rmt_pkg::F_LAV] = 1'b1;
				if (c_q.join_req) n_fl[rmt_pkg::F_MAV] = 1'b1;
				n_tact = 1'b0;
			end
			if (detect || nondup || directed) begin
				n_base = c_q.now_sec; n_tact = 1'b1;
			end
			if (detect) n_st = rmt_pkg::S_DETECT;
			if (nondup) n_st = rmt_pkg::S_NONOP_DUP;
			if (directed) begin n_st = rmt_pkg::S_DIRECTED; n_sdb = 1'b1; end
			if (rdup) begin n_st = rmt_pkg::S_RINGOP_DUP; n_tact = 1'b0; end
			if (trace_e) begin
				n_st = rmt_pkg::S_TRACE; n_ecm = rmt_pkg::ECM_TRACE;
				n_ts = rmt_pkg::TS_INIT; n_str = 1'b1; n_tact = 1'b0;
			end
		end
	end

	// captured conditions and backoff product
	always_ff @(posedge clk) begin
		if (ctl.load) c_q <= in_data;
		if (ctl.mul) prod_q <= flop_q * cfg.sulk_unit;
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rmt_pkg::S_ISO;
			fl_q <= 7'd1;
			base_q <= '0;
			tact_q <= 1'b0;
			flop_q <= '0;
			dupf_q <= 1'b0;
			marked_q <= 1'b0;
			dupa_q <= rmt_pkg::DAT_UNKNOWN;
			ecm_q <= rmt_pkg::ECM_OUT;
			ts_q <= rmt_pkg::TS_NONE;
			sdb_q <= 1'b0; stdb_q <= 1'b0; str_q <= 1'b0; alarm_q <= 1'b0;
			mrr_q <= rmt_pkg::MRR_NONE;
			run_q <= 1'b0;
		end else if (ctl.load || ctl.step) begin
			st_q <= n_st; fl_q <= n_fl; base_q <= n_base; tact_q <= n_tact;
			flop_q <= n_flop; dupf_q <= n_dupf; marked_q <= n_marked;
			dupa_q <= n_dupa; ecm_q <= n_ecm; ts_q <= n_ts;
			sdb_q <= n_sdb; stdb_q <= n_stdb; str_q <= n_str; alarm_q <= n_alarm;
			mrr_q <= n_mrr;
			if (ctl.load) run_q <= n_run;
		end
	end

	// result view
	assign out_data.rm_state = st_q;
	assign out_data.ecm_code = ecm_q;
	assign out_data.trace_status = ts_q;
	assign out_data.loop_avail = fl_q[rmt_pkg::F_LAV];
	assign out_data.mac_avail = fl_q[rmt_pkg::F_MAV];
	assign out_data.dup_addr_flag = dupf_q;
	assign out_data.start_directed_beacon = sdb_q;
	assign out_data.stop_directed_beacon = stdb_q;
	assign out_data.start_trace = str_q;
	assign out_data.mac_reset_request = mrr_q;
	assign out_data.dup_alarm = alarm_q;
	assign out_data.timer_running = tact_q;
endmodule

/* rtl/core/rmt_cfg.sv */
// ring management configuration register file
// depends on rmt_pkg
module rmt_cfg (
	input logic clk,
	input logic arst_n,
	rmt_cfg_if.sink cfg_ch,
	output rmt_pkg::rmt_cfg_t cfg
);
	assign cfg_ch.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.trace_enable <= 1'b1;
			cfg.hold_available <= 1'b0;
			cfg.non_op_time <= 8'd1;
			cfg.stuck_time <= 8'd8;
			cfg.announce_time <= 8'd2;
			cfg.direct_time <= 8'd1;
			cfg.sulk_unit <= 10'd60;
			cfg.max_flops <= 4'd5;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				rmt_pkg::R_TRACE_EN: cfg.trace_enable <= cfg_ch.wdata[0];
				rmt_pkg::R_HOLD: cfg.hold_available <= cfg_ch.wdata[0];
				rmt_pkg::R_NONOP_T: cfg.non_op_time <= cfg_ch.wdata[7:0];
				rmt_pkg::R_STUCK_T: cfg.stuck_time <= cfg_ch.wdata[7:0];
				rmt_pkg::R_ANNOUNCE_T: cfg.announce_time <= cfg_ch.wdata[7:0];
				rmt_pkg::R_DIRECT_T: cfg.direct_time <= cfg_ch.wdata[7:0];
				rmt_pkg::R_SULK: cfg.sulk_unit <= cfg_ch.wdata;
				rmt_pkg::R_MAX_FLOPS: cfg.max_flops <= cfg_ch.wdata[3:0];
				default: ;
			endcase
		end
	end
endmodule

/* rtl/core/ring_management_state_machine_top.sv */
// ring management state machine top level
// depends on rmt_pkg, rmt_if, rmt_cfg, rmt_ctrl, rmt_dp
//
// Usage: requests enter on in_ch (valid/ready); each gives exactly one
// result on out_ch. Configuration writes go over cfg_ch (always ready,
// index 0..7); the user must issue them only while the block is idle, which the block itself does not enforce.
// Flow: an accepted request first passes through a backoff multiply
// step; if it runs no evaluation its result is then valid. An evaluation
// runs state body passes (1 to 8): a pass whose transition chains is
// followed by another, and the last pass is one that does not chain or
// the eighth. Each pass is a backoff multiply step followed by a state
// body step. The block takes one request at a time, so the next one is
// accepted the cycle after its result is taken.
// Reset: state isolated, no-op flag set, timer stopped, registers at
// their defaults.
// Stall: the result stays on out_ch until ready; input is held off.
module ring_management_state_machine_top (
	input logic clk,
	input logic arst_n,
	rmt_in_if.sink in_ch,
	rmt_out_if.source out_ch,
	rmt_cfg_if.sink cfg_ch
);
	rmt_pkg::rmt_cfg_t cfg;
	rmt_pkg::rmt_ctl_t ctl;
	rmt_pkg::rmt_sts_t sts;

	rmt_cfg u_cfg (.clk(clk), .arst_n(arst_n), .cfg_ch(cfg_ch), .cfg(cfg));

	rmt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.ctl(ctl), .sts(sts)
	);

	rmt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_data(in_ch.data),
		.ctl(ctl), .sts(sts), .out_data(out_ch.data)
	);

`ifndef SYNTHESIS
	// input is never ready while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while result pending");
	// load and pass never coincide
	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load && ctl.step))
		else $error("load and pass together");
	// an accepted request leaves the idle state
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("still idle after accept");
`endif
endmodule
